// File: rtl/core/complex_number_alu_defines.svh
// Assertion macros for the complex number ALU.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_NUMBER_ALU_DEFINES_SVH
`define COMPLEX_NUMBER_ALU_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication check
`define CNA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("complex_number_alu: same-cycle check failed");
// next-cycle implication check
`define CNA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("complex_number_alu: next-cycle check failed");
`else
`define CNA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CNA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/cna_pkg.sv
// Shared types, constants and helper functions for the complex number ALU.
// No dependencies; imported by every module of the block.
package cna_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int EXT_BITS  = PROD_BITS + 1;
    localparam int REM_BITS  = 3 * WORD_BITS;
    localparam int IDX_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2,
        OP_MAG = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t WORD_ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};
    localparam logic [REM_BITS-1:0] REM_ONE = {{(REM_BITS-1){1'b0}}, 1'b1};
    localparam logic signed [EXT_BITS-1:0] FRAC_BIAS =
        {{(EXT_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    typedef struct packed {
        word_t v;
        logic  sat;
    } sat_word_t;

    // Everything one item carries down the divide / root chain
    typedef struct packed {
        logic                  valid;
        op_t                   op;
        word_t                 res_re;
        word_t                 res_im;
        logic                  sat;
        logic                  div_zero;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [PROD_BITS-1:0]  den;
        logic [REM_BITS-1:0]   rem_re;
        logic [REM_BITS-1:0]   rem_im;
        word_t                 q_re;
        word_t                 q_im;
    } cell_t;

    typedef struct packed {
        word_t   re;
        word_t   im;
        status_t status;
    } result_t;

    // Clamp a wide signed value to the word range
    function automatic sat_word_t clamp_ext(input logic signed [EXT_BITS-1:0] x);
        logic signed [EXT_BITS-1:0] hi;
        logic signed [EXT_BITS-1:0] lo;
        sat_word_t r;
        hi = {{(EXT_BITS-WORD_BITS){1'b0}}, WORD_MAX};
        lo = {{(EXT_BITS-WORD_BITS){1'b1}}, WORD_MIN};
        if (x > hi) begin
            r.v   = WORD_MAX;
            r.sat = 1'b1;
        end else if (x < lo) begin
            r.v   = WORD_MIN;
            r.sat = 1'b1;
        end else begin
            r.v   = x[WORD_BITS-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Sign-magnitude quotient to two's complement, with clamping
    function automatic sat_word_t pack_mag(input logic neg, input logic ovf, input word_t q);
        sat_word_t r;
        if (neg) begin
            if (ovf || (q > WORD_MIN)) begin
                r.v   = WORD_MIN;
                r.sat = 1'b1;
            end else begin
                r.v   = word_t'(~q + WORD_ONE);
                r.sat = 1'b0;
            end
        end else begin
            if (ovf || q[WORD_BITS-1]) begin
                r.v   = WORD_MAX;
                r.sat = 1'b1;
            end else begin
                r.v   = q;
                r.sat = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cna_front.sv
// Front end of the complex number ALU: products, sums and setup of the digit chain.
// Depends on cna_pkg.
module cna_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [1:0]                             func,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   a_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   a_im,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   b_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   b_im,
    output cna_pkg::cell_t                         head
);
    import cna_pkg::*;

    // ---------------- stage A: products and plain sums
    op_t                          op_in;
    logic signed [WORD_BITS-1:0]  sq0_in;
    logic signed [WORD_BITS-1:0]  sq1_in;

    logic                         a_valid_reg;
    op_t                          a_op_reg;
    logic signed [PROD_BITS-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_BITS-1:0]  p_sq0_reg, p_sq1_reg;
    logic signed [WORD_BITS:0]    sum_re_reg, sum_im_reg;

    assign op_in  = op_t'(func);
    // magnitude squares a, divide squares b
    assign sq0_in = (op_in == OP_MAG) ? a_re : b_re;
    assign sq1_in = (op_in == OP_MAG) ? a_im : b_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_op_reg   <= op_in;
            p_rr_reg   <= PROD_BITS'(a_re) * PROD_BITS'(b_re);
            p_ii_reg   <= PROD_BITS'(a_im) * PROD_BITS'(b_im);
            p_ri_reg   <= PROD_BITS'(a_re) * PROD_BITS'(b_im);
            p_ir_reg   <= PROD_BITS'(a_im) * PROD_BITS'(b_re);
            p_sq0_reg  <= PROD_BITS'(sq0_in) * PROD_BITS'(sq0_in);
            p_sq1_reg  <= PROD_BITS'(sq1_in) * PROD_BITS'(sq1_in);
            sum_re_reg <= (WORD_BITS+1)'(a_re) + (WORD_BITS+1)'(b_re);
            sum_im_reg <= (WORD_BITS+1)'(a_im) + (WORD_BITS+1)'(b_im);
        end
    end

    // ---------------- stage B: cross sums and denominator
    logic signed [EXT_BITS-1:0]  e_rr, e_ii, e_ri, e_ir;
    logic signed [EXT_BITS-1:0]  n_re_next, n_im_next;
    logic [PROD_BITS-1:0]        den_next;

    logic                        b_valid_reg;
    op_t                         b_op_reg;
    logic signed [EXT_BITS-1:0]  n_re_reg, n_im_reg;
    logic [PROD_BITS-1:0]        den_reg;

    assign e_rr = EXT_BITS'(p_rr_reg);
    assign e_ii = EXT_BITS'(p_ii_reg);
    assign e_ri = EXT_BITS'(p_ri_reg);
    assign e_ir = EXT_BITS'(p_ir_reg);
    assign den_next = p_sq0_reg + p_sq1_reg;

    always_comb begin
        case (a_op_reg)
            OP_ADD: begin
                n_re_next = EXT_BITS'(sum_re_reg);
                n_im_next = EXT_BITS'(sum_im_reg);
            end
            OP_MUL: begin
                n_re_next = e_rr - e_ii;
                n_im_next = e_ri + e_ir;
            end
            default: begin
                // numerator of a * conj(b)
                n_re_next = e_rr + e_ii;
                n_im_next = e_ir - e_ri;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_op_reg <= a_op_reg;
            n_re_reg <= n_re_next;
            n_im_reg <= n_im_next;
            den_reg  <= den_next;
        end
    end

    // ---------------- stage C: finish add/mul, set up division and root
    logic signed [EXT_BITS-1:0]  t_re, t_im, sh_re, sh_im, ng_re, ng_im;
    logic [PROD_BITS-1:0]        mag_re, mag_im;
    logic [REM_BITS-1:0]         rdiv_re, rdiv_im;
    sat_word_t                   c_re, c_im;
    cell_t                       head_next;

    logic                        c_valid_reg;
    cell_t                       c_data_reg;

    // truncation toward zero for the product shift
    assign t_re  = n_re_reg + (n_re_reg[EXT_BITS-1] ? FRAC_BIAS : '0);
    assign t_im  = n_im_reg + (n_im_reg[EXT_BITS-1] ? FRAC_BIAS : '0);
    assign sh_re = t_re >>> FRAC_BITS;
    assign sh_im = t_im >>> FRAC_BITS;

    assign ng_re  = -n_re_reg;
    assign ng_im  = -n_im_reg;
    assign mag_re = n_re_reg[EXT_BITS-1] ? ng_re[PROD_BITS-1:0] : n_re_reg[PROD_BITS-1:0];
    assign mag_im = n_im_reg[EXT_BITS-1] ? ng_im[PROD_BITS-1:0] : n_im_reg[PROD_BITS-1:0];
    assign rdiv_re = REM_BITS'({mag_re, {FRAC_BITS{1'b0}}});
    assign rdiv_im = REM_BITS'({mag_im, {FRAC_BITS{1'b0}}});

    always_comb begin
        if (b_op_reg == OP_ADD) begin
            c_re = clamp_ext(n_re_reg);
            c_im = clamp_ext(n_im_reg);
        end else begin
            c_re = clamp_ext(sh_re);
            c_im = clamp_ext(sh_im);
        end
        head_next          = '0;
        head_next.valid    = b_valid_reg;
        head_next.op       = b_op_reg;
        head_next.res_re   = c_re.v;
        head_next.res_im   = c_im.v;
        head_next.sat      = c_re.sat | c_im.sat;
        head_next.div_zero = (den_reg == '0);
        head_next.neg_re   = n_re_reg[EXT_BITS-1];
        head_next.neg_im   = n_im_reg[EXT_BITS-1];
        // quotient would need more than a word
        head_next.ovf_re   = (mag_re >> (WORD_BITS - FRAC_BITS)) >= den_reg;
        head_next.ovf_im   = (mag_im >> (WORD_BITS - FRAC_BITS)) >= den_reg;
        head_next.den      = den_reg;
        head_next.rem_re   = (b_op_reg == OP_MAG) ? REM_BITS'(den_reg) : rdiv_re;
        head_next.rem_im   = rdiv_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_data_reg <= head_next;
        end
    end

    always_comb begin
        head       = c_data_reg;
        head.valid = c_valid_reg;
    end

endmodule

// File: rtl/core/cna_cell.sv
// One digit cell of the chain: a quotient bit for divide or a root bit for magnitude.
// Depends on cna_pkg.
module cna_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic [cna_pkg::IDX_BITS-1:0]     idx,
    input  cna_pkg::cell_t                   d_in,
    output cna_pkg::cell_t                   d_out
);
    import cna_pkg::*;

    logic [REM_BITS-1:0]   d_step;
    logic [REM_BITS-1:0]   r_step;
    logic [IDX_BITS:0]     idx_up;
    word_t                 bit_k;
    cell_t                 d_next;

    logic                  valid_reg;
    cell_t                 data_reg;

    // divisor aligned to this bit
    assign d_step = REM_BITS'(d_in.den) << idx;
    // root trial: 2*r*2^k + 2^(2k)
    assign idx_up = (IDX_BITS+1)'(idx) + (IDX_BITS+1)'(1);
    assign r_step = (REM_BITS'(d_in.q_re) << idx_up) + (REM_ONE << {idx, 1'b0});
    assign bit_k  = WORD_ONE << idx;

    always_comb begin
        d_next = d_in;
        case (d_in.op)
            OP_DIV: begin
                if (d_in.rem_re >= d_step) begin
                    d_next.rem_re = d_in.rem_re - d_step;
                    d_next.q_re   = d_in.q_re | bit_k;
                end
                if (d_in.rem_im >= d_step) begin
                    d_next.rem_im = d_in.rem_im - d_step;
                    d_next.q_im   = d_in.q_im | bit_k;
                end
            end
            OP_MAG: begin
                if (d_in.rem_re >= r_step) begin
                    d_next.rem_re = d_in.rem_re - r_step;
                    d_next.q_re   = d_in.q_re | bit_k;
                end
            end
            default: begin
                d_next = d_in;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= d_next;
        end
    end

    always_comb begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

// File: rtl/core/complex_number_alu.sv
// Top level of the complex number ALU: front end, digit chain, output register and skid.
// Depends on cna_pkg, cna_front, cna_cell and complex_number_alu_defines.svh.
//
//  channel | direction | signals
//  s_      | request   | s_valid s_ready s_func s_a_re s_a_im s_b_re s_b_im
//  m_      | result    | m_valid m_ready m_res_re m_res_im m_status
//
// One request per cycle while s_ready is high; each result passes the front end, the row of
// one-bit cells that forms quotient and root digits, and the output register.
// Reset clears only valid bits; no clearing pass.
// A stalled result is held in the output register; one more sits in the skid
// stage, after which s_ready drops and the whole pipe holds.
`include "complex_number_alu_defines.svh"

module complex_number_alu (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_func,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   s_a_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   s_a_im,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   s_b_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0]   s_b_im,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [cna_pkg::WORD_BITS-1:0]   m_res_re,
    output logic signed [cna_pkg::WORD_BITS-1:0]   m_res_im,
    output logic [1:0]                             m_status
);
    import cna_pkg::*;

    logic      en;
    cell_t     chain [0:WORD_BITS];
    cell_t     tail;
    sat_word_t pk_re, pk_im, pk_mag;
    result_t   fin;
    logic      load_out;

    logic      out_valid_reg;
    result_t   out_reg;
    logic      skid_valid_reg;
    result_t   skid_reg;

    // pipe runs while the skid stage is empty
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    cna_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .func     (s_func),
        .a_re     (s_a_re),
        .a_im     (s_a_im),
        .b_re     (s_b_re),
        .b_im     (s_b_im),
        .head     (chain[0])
    );

    // digit cells, most significant bit first
    for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
        localparam logic [IDX_BITS-1:0] CELL_IDX = IDX_BITS'(WORD_BITS - 1 - i);
        cna_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (CELL_IDX),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    assign tail = chain[WORD_BITS];

    // final sign, clamp and status
    assign pk_re  = pack_mag(tail.neg_re, tail.ovf_re, tail.q_re);
    assign pk_im  = pack_mag(tail.neg_im, tail.ovf_im, tail.q_im);
    assign pk_mag = pack_mag(1'b0, 1'b0, tail.q_re);

    always_comb begin
        case (tail.op)
            OP_ADD, OP_MUL: begin
                fin.re     = tail.res_re;
                fin.im     = tail.res_im;
                fin.status = tail.sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (tail.div_zero) begin
                    fin.re     = '0;
                    fin.im     = '0;
                    fin.status = ST_DIV_ZERO;
                end else begin
                    fin.re     = pk_re.v;
                    fin.im     = pk_im.v;
                    fin.status = (pk_re.sat | pk_im.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                fin.re     = pk_mag.v;
                fin.im     = '0;
                fin.status = pk_mag.sat ? ST_SAT : ST_OK;
            end
            default: begin
                fin.re     = '0;
                fin.im     = '0;
                fin.status = ST_OK;
            end
        endcase
    end

    // output register with skid
    assign load_out = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= tail.valid;
            end
        end else if (en && tail.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end else if (en && tail.valid) begin
            skid_reg <= fin;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_res_re = out_reg.re;
    assign m_res_im = out_reg.im;
    assign m_status = out_reg.status;

    // checks
    `CNA_ASSERT_IMP(a_skid_implies_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `CNA_ASSERT_IMP(a_div_zero_clears, aclk, aresetn, m_valid && (m_status == ST_DIV_ZERO), (m_res_re == '0) && (m_res_im == '0))
    `CNA_ASSERT_NXT(a_taken_no_skid, aclk, aresetn, m_valid && m_ready && !skid_valid_reg, !skid_valid_reg)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for complex_number_alu: add, multiply, divide and magnitude.
// Depends on cna_pkg for widths, operation and status codes; predicts with wide arithmetic.
`timescale 1ns / 1ps

module testbench;
    import cna_pkg::*;

    typedef logic signed [129:0] wide_t;

    typedef struct {
        op_t                        func;
        logic signed [WORD_BITS-1:0] a_re, a_im, b_re, b_im;
    } request_t;

    typedef struct {
        logic signed [WORD_BITS-1:0] re, im;
        status_t                     status;
    } alu_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic signed [WORD_BITS-1:0] s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [WORD_BITS-1:0] m_res_re, m_res_im;
    logic [1:0] m_status;

    request_t    pending_reqs[$];
    alu_result_t expected_results[$];
    int          n_errors = 0;
    int          n_accepted = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 0;

    complex_number_alu i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Clamp a wide value to the word; flags saturation
    function automatic logic signed [WORD_BITS-1:0] clamp_word(input wide_t x, inout logic sat);
        wide_t hi, lo;
        hi = wide_t'(WORD_MAX);
        lo = -hi - 1;
        if (x > hi) begin
            sat = 1'b1;
            return WORD_MAX;
        end else if (x < lo) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return x[WORD_BITS-1:0];
    endfunction

    // Truncating shift toward zero
    function automatic wide_t shr_trunc(input wide_t x);
        if (x < 0) return -((-x) >>> FRAC_BITS);
        return x >>> FRAC_BITS;
    endfunction

    // Quotient n * 2^F / d truncated toward zero, d positive
    function automatic wide_t div_trunc(input wide_t n, input wide_t d);
        wide_t m;
        m = (n < 0) ? -n : n;
        m = (m <<< FRAC_BITS) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic alu_result_t predict_alu(input request_t r);
        alu_result_t res;
        logic  sat;
        wide_t ar, ai, br, bi, t1, t2, den, s, root, c;
        sat = 1'b0;
        ar = wide_t'(r.a_re);
        ai = wide_t'(r.a_im);
        br = wide_t'(r.b_re);
        bi = wide_t'(r.b_im);
        res.status = ST_OK;
        res.re = '0;
        res.im = '0;
        case (r.func)
            OP_ADD: begin
                res.re = clamp_word(ar + br, sat);
                res.im = clamp_word(ai + bi, sat);
            end
            OP_MUL: begin
                res.re = clamp_word(shr_trunc(ar * br - ai * bi), sat);
                res.im = clamp_word(shr_trunc(ar * bi + ai * br), sat);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    res.status = ST_DIV_ZERO;
                end else begin
                    t1 = ar * br + ai * bi;
                    t2 = ai * br - ar * bi;
                    res.re = clamp_word(div_trunc(t1, den), sat);
                    res.im = clamp_word(div_trunc(t2, den), sat);
                end
            end
            default: begin
                s = ar * ar + ai * ai;
                root = 0;
                for (int b = 63; b >= 0; b--) begin
                    c = root | (wide_t'(1) <<< b);
                    if (c * c <= s) root = c;
                end
                res.re = clamp_word(root, sat);
            end
        endcase
        if (res.status == ST_OK && sat) res.status = ST_SAT;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Operand mix: extremes, small values, near-unit values, full random
    function automatic logic signed [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return $signed($urandom_range(0, 64)) - 32;
            4: return ($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
            5: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic request_t make_req(input op_t f, input logic signed [WORD_BITS-1:0] a,
                                          b, c, d);
        request_t r;
        r.func = f;
        r.a_re = a;
        r.a_im = b;
        r.b_re = c;
        r.b_im = d;
        return r;
    endfunction

    // Stimulus
    initial begin
        request_t r;
        pending_reqs.push_back(make_req(OP_ADD, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        pending_reqs.push_back(make_req(OP_ADD, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        pending_reqs.push_back(make_req(OP_ADD, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX));
        pending_reqs.push_back(make_req(OP_ADD, 32'sh10000, -32'sh8000, 32'sh1, -32'sh1));
        pending_reqs.push_back(make_req(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        pending_reqs.push_back(make_req(OP_MUL, WORD_MIN, 0, WORD_MIN, 0));
        pending_reqs.push_back(make_req(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN));
        pending_reqs.push_back(make_req(OP_MUL, -32'sh1, 32'sh1, 32'sh8000, 32'sh8000));
        pending_reqs.push_back(make_req(OP_MUL, 32'sh18000, -32'sh20000, 32'sh10000, -3));
        pending_reqs.push_back(make_req(OP_DIV, 32'sh10000, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_DIV, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_DIV, WORD_MAX, WORD_MIN, 0, 1));
        pending_reqs.push_back(make_req(OP_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        pending_reqs.push_back(make_req(OP_DIV, WORD_MIN, 0, 32'sh10000, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32'sh30000, -32'sh10000, 32'sh10000, 32'sh20000));
        pending_reqs.push_back(make_req(OP_DIV, -7, 3, WORD_MAX, WORD_MAX));
        pending_reqs.push_back(make_req(OP_MAG, WORD_MIN, WORD_MIN, 5, 6));
        pending_reqs.push_back(make_req(OP_MAG, WORD_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_MAG, 0, 0, WORD_MAX, WORD_MIN));
        pending_reqs.push_back(make_req(OP_MAG, 32'sh30000, -32'sh40000, 0, 0));
        pending_reqs.push_back(make_req(OP_MAG, -1, 1, 0, 0));
        repeat (1850) begin
            r = make_req(op_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                         rand_word(), rand_word());
            pending_reqs.push_back(r);
        end
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("complex_number_alu: match");
        end else begin
            $display("complex_number_alu: mismatch");
        end
        $finish;
    end

    // Request driver; sender idle rate depends on the phase
    always @(posedge aclk) begin
        int idle_pct;
        request_t r;
        idle_pct = (n_accepted < 600) ? 34 : (n_accepted < 1200) ? 63 : 0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                r = make_req(op_t'(s_func), s_a_re, s_a_im, s_b_re, s_b_im);
                expected_results.push_back(predict_alu(r));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_func  <= r.func;
                    s_a_re  <= r.a_re;
                    s_a_im  <= r.a_im;
                    s_b_re  <= r.b_re;
                    s_b_im  <= r.b_im;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off to fill the pipe
    always @(posedge aclk) begin
        int stall_pct;
        stall_pct = (n_accepted < 600) ? 63 : (n_accepted < 1200) ? 34 : 0;
        if (!holdoff_done && n_accepted >= 300) begin
            holdoff_done <= 1;
            holdoff_left <= 200;
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_res_re, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_res_re !== want.re) report_mismatch("res_re", m_res_re, want.re);
                if (m_res_im !== want.im) report_mismatch("res_im", m_res_im, want.im);
                if (m_status !== want.status) report_mismatch("status", m_status, want.status);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("complex_number_alu: mismatch");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cna_pkg.sv
rtl/core/cna_front.sv
rtl/core/cna_cell.sv
rtl/core/complex_number_alu.sv
tb/testbench.sv
